/* hw/rtl/cartridge_bank_mapper_with_irq_top_macros.svh */
// assertion macros for the cartridge bank mapper checker
// depends on nothing; included by the checker file only
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_MACROS_SVH

// same-cycle implication
`define CBM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cbm_pkg.sv */
// shared types and constants for the cartridge bank mapper
// no dependencies
package cbm_pkg;

   localparam logic        OP_WRITE = 1'b0;
   localparam logic        OP_CLOCK = 1'b1;

   localparam logic [15:0] DECODE_MASK   = 16'h8C17;
   localparam logic [15:0] ADDR_BANK     = 16'h8000;
   localparam logic [15:0] ADDR_MODE     = 16'h8400;
   localparam logic [15:0] ADDR_CNT_LO   = 16'h8800;
   localparam logic [15:0] ADDR_CNT_HI   = 16'h8801;
   localparam logic [15:0] ADDR_TBL0     = 16'h8C00;
   localparam logic [15:0] ADDR_TBL1     = 16'h8C01;
   localparam logic [15:0] ADDR_TBL2     = 16'h8C02;
   localparam logic [15:0] ADDR_TBL3     = 16'h8C10;
   localparam logic [15:0] ADDR_TBL4     = 16'h8C11;
   localparam logic [15:0] ADDR_TBL5     = 16'h8C16;
   localparam logic [15:0] ADDR_TBL6     = 16'h8C17;

   localparam logic [15:0] CNT_RELOAD    = 16'hFFFF;
   localparam logic [9:0]  BANK_COUNT_RST = 10'd32;

   localparam int          TBL_DEPTH = 7;

   // mode register bits
   localparam int          MODE_MIRROR_BIT = 0;
   localparam int          MODE_32K_BIT    = 3;
   localparam int          MODE_WINDOW_BIT = 4;
   localparam int          MODE_ARM_BIT    = 7;

   typedef struct packed {
      logic [7:0]       bank;
      logic [7:0]       mode;
      logic [2:0][7:0]  prg_tbl;
      logic [9:0]       bank_count;
   } map_state_type;

   typedef logic [3:0][8:0] prg_slots_type;

endpackage

/* hw/rtl/cbm_prg_map.sv */
// prg slot mapping from the bank, mode and table registers
// depends on cbm_pkg
module cbm_prg_map
   import cbm_pkg::*;
(
   input  map_state_type  map_state,
   output prg_slots_type  prg_slots
);

   logic [9:0] fixed_lo;
   logic [9:0] fixed_hi;

   assign fixed_lo = map_state.bank_count - 10'd2;
   assign fixed_hi = map_state.bank_count - 10'd1;

   always_comb begin
      if (map_state.mode[MODE_WINDOW_BIT]) begin
         prg_slots[0] = {4'b0, map_state.bank[3], map_state.prg_tbl[0][3:0]};
         prg_slots[1] = {4'b0, map_state.bank[3], map_state.prg_tbl[1][3:0]};
         prg_slots[2] = {4'b0, map_state.bank[3], map_state.prg_tbl[2][3:0]};
         prg_slots[3] = {4'b0, map_state.bank[3], 4'hF};
      end else if (map_state.mode[MODE_32K_BIT]) begin
         prg_slots[0] = {map_state.bank[7:1], 2'd0};
         prg_slots[1] = {map_state.bank[7:1], 2'd1};
         prg_slots[2] = {map_state.bank[7:1], 2'd2};
         prg_slots[3] = {map_state.bank[7:1], 2'd3};
      end else begin
         prg_slots[0] = {map_state.bank, 1'b0};
         prg_slots[1] = {map_state.bank, 1'b1};
         prg_slots[2] = fixed_lo[8:0];
         prg_slots[3] = fixed_hi[8:0];
      end
   end

endmodule

/* hw/rtl/cartridge_bank_mapper_with_irq_top.sv */
// each result word appears in the cycle after its word is accepted
// throughput: one word per cycle unless the result side stalls; decode,
// counter subtract and prg mapping all sit between the state registers
// and the result register; reset: synchronous, active high; clears all
// mapper state, disarms the irq and sets the prg bank count to 32
module cartridge_bank_mapper_with_irq_top
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [9:0]  req_cycles,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_prg_slot0_bank,
   output logic [8:0]  rsp_prg_slot1_bank,
   output logic [8:0]  rsp_prg_slot2_bank,
   output logic [8:0]  rsp_prg_slot3_bank,
   output logic [7:0]  rsp_chr_slot0_bank,
   output logic [7:0]  rsp_chr_slot1_bank,
   output logic [7:0]  rsp_chr_slot2_bank,
   output logic [7:0]  rsp_chr_slot3_bank,
   output logic        rsp_mirror_select,
   output logic        rsp_irq_level
);

   logic [9:0]  bank_count_ff;
   logic [7:0]  bank_ff,    bank_in;
   logic [7:0]  mode_ff,    mode_in;
   logic [7:0]  tbl_ff [TBL_DEPTH];
   logic [7:0]  tbl_in [TBL_DEPTH];
   logic [15:0] counter_ff, counter_in;
   logic        armed_ff,   armed_in;
   logic        pending_ff, pending_in;

   logic        rsp_valid_ff;
   logic [3:0][8:0] rsp_prg_ff;
   logic [3:0][7:0] rsp_chr_ff;
   logic        rsp_mirror_ff;
   logic        rsp_irq_ff;

   logic        accept;
   logic [15:0] decoded;
   logic [15:0] cycles_ext;
   map_state_type map_state;
   prg_slots_type prg_slots;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign decoded    = req_address & DECODE_MASK;
   assign cycles_ext = {6'b0, req_cycles};

   always_comb begin
      bank_in    = bank_ff;
      mode_in    = mode_ff;
      tbl_in     = tbl_ff;
      counter_in = counter_ff;
      armed_in   = armed_ff;
      pending_in = pending_ff;
      if (req_op == OP_WRITE) begin
         case (decoded)
            ADDR_BANK: bank_in = req_data;
            ADDR_MODE: mode_in = req_data;
            ADDR_CNT_LO: begin
               counter_in = {counter_ff[15:8], req_data};
               pending_in = 1'b0;
            end
            ADDR_CNT_HI: begin
               counter_in = {req_data, counter_ff[7:0]};
               armed_in   = mode_ff[MODE_ARM_BIT];
            end
            ADDR_TBL0: tbl_in[0] = req_data;
            ADDR_TBL1: tbl_in[1] = req_data;
            ADDR_TBL2: tbl_in[2] = req_data;
            ADDR_TBL3: tbl_in[3] = req_data;
            ADDR_TBL4: tbl_in[4] = req_data;
            ADDR_TBL5: tbl_in[5] = req_data;
            ADDR_TBL6: tbl_in[6] = req_data;
            default: ;
         endcase
      end else if (armed_ff) begin
         if (cycles_ext > counter_ff) begin
            pending_in = 1'b1;
            armed_in   = 1'b0;
            counter_in = CNT_RELOAD;
         end else begin
            counter_in = counter_ff - cycles_ext;
         end
      end
   end

   // result is mapped from the state after this word
   assign map_state.bank       = bank_in;
   assign map_state.mode       = mode_in;
   assign map_state.prg_tbl[0] = tbl_in[0];
   assign map_state.prg_tbl[1] = tbl_in[1];
   assign map_state.prg_tbl[2] = tbl_in[2];
   assign map_state.bank_count = bank_count_ff;

   cbm_prg_map u_prg_map (
      .map_state (map_state),
      .prg_slots (prg_slots)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff <= BANK_COUNT_RST;
      end else if (csr_wr_en) begin
         bank_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff    <= '0;
         mode_ff    <= '0;
         counter_ff <= '0;
         armed_ff   <= 1'b0;
         pending_ff <= 1'b0;
         for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_ff[i] <= '0;
         end
      end else if (accept) begin
         bank_ff    <= bank_in;
         mode_ff    <= mode_in;
         counter_ff <= counter_in;
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         tbl_ff     <= tbl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_prg_ff    <= prg_slots;
         rsp_chr_ff[0] <= tbl_in[3];
         rsp_chr_ff[1] <= tbl_in[4];
         rsp_chr_ff[2] <= tbl_in[5];
         rsp_chr_ff[3] <= tbl_in[6];
         rsp_mirror_ff <= ~mode_in[MODE_MIRROR_BIT];
         rsp_irq_ff    <= pending_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prg_slot0_bank = rsp_prg_ff[0];
   assign rsp_prg_slot1_bank = rsp_prg_ff[1];
   assign rsp_prg_slot2_bank = rsp_prg_ff[2];
   assign rsp_prg_slot3_bank = rsp_prg_ff[3];
   assign rsp_chr_slot0_bank = rsp_chr_ff[0];
   assign rsp_chr_slot1_bank = rsp_chr_ff[1];
   assign rsp_chr_slot2_bank = rsp_chr_ff[2];
   assign rsp_chr_slot3_bank = rsp_chr_ff[3];
   assign rsp_mirror_select  = rsp_mirror_ff;
   assign rsp_irq_level      = rsp_irq_ff;

endmodule

/* hw/rtl/cbm_checker.sv */
// port-level checks for the cartridge bank mapper, bound to the top level
// depends on cbm_pkg and cartridge_bank_mapper_with_irq_top_macros.svh
`include "cartridge_bank_mapper_with_irq_top_macros.svh"

module cbm_checker
   import cbm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [8:0]  rsp_prg_slot0_bank,
   input logic [8:0]  rsp_prg_slot1_bank,
   input logic [8:0]  rsp_prg_slot2_bank,
   input logic [8:0]  rsp_prg_slot3_bank,
   input logic [7:0]  rsp_chr_slot0_bank,
   input logic [7:0]  rsp_chr_slot1_bank,
   input logic [7:0]  rsp_chr_slot2_bank,
   input logic [7:0]  rsp_chr_slot3_bank,
   input logic        rsp_mirror_select,
   input logic        rsp_irq_level
);

   logic        req_take;
   logic [69:0] rsp_word;

   assign req_take = req_valid & ~req_stall;
   assign rsp_word = {rsp_prg_slot0_bank, rsp_prg_slot1_bank, rsp_prg_slot2_bank,
                      rsp_prg_slot3_bank, rsp_chr_slot0_bank, rsp_chr_slot1_bank,
                      rsp_chr_slot2_bank, rsp_chr_slot3_bank, rsp_mirror_select,
                      rsp_irq_level};

   `CBM_ASSERT_IMPL(a_stall_only_when_full, req_stall, rsp_valid, "stall without a waiting word")
   `CBM_ASSERT_NEXT(a_take_gives_word, req_take, rsp_valid, "accepted word gave no result")
   `CBM_ASSERT_NEXT(a_drain_empties, rsp_valid && !rsp_stall && !req_take, !rsp_valid, "result repeated")
   `CBM_ASSERT_NEXT(a_stalled_word_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result changed")
   `CBM_ASSERT_NEXT(a_write_never_raises_irq, req_take && req_op == OP_WRITE && rsp_valid && !rsp_irq_level, !rsp_irq_level, "irq raised by a write")

endmodule

bind cartridge_bank_mapper_with_irq_top cbm_checker u_cbm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_op             (req_op),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_prg_slot0_bank (rsp_prg_slot0_bank),
   .rsp_prg_slot1_bank (rsp_prg_slot1_bank),
   .rsp_prg_slot2_bank (rsp_prg_slot2_bank),
   .rsp_prg_slot3_bank (rsp_prg_slot3_bank),
   .rsp_chr_slot0_bank (rsp_chr_slot0_bank),
   .rsp_chr_slot1_bank (rsp_chr_slot1_bank),
   .rsp_chr_slot2_bank (rsp_chr_slot2_bank),
   .rsp_chr_slot3_bank (rsp_chr_slot3_bank),
   .rsp_mirror_select  (rsp_mirror_select),
   .rsp_irq_level      (rsp_irq_level)
);

/* dv/cartridge_bank_mapper_with_irq_top_test.sv */
// self-checking bench for the cartridge bank mapper: banks, prg modes, mirroring, irq counter
// depends on cbm_pkg and cartridge_bank_mapper_with_irq_top; drives words from a queue,
// predicts each result word in-line and checks it at the result port
module cartridge_bank_mapper_with_irq_top_test
   import cbm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 235;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic        op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [9:0]  cycles;
   } bus_word_type;

   typedef struct packed {
      prg_slots_type   prg;
      logic [3:0][7:0] chr;
      logic            mirror;
      logic            irq;
   } bank_map_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_WRITE;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic [9:0]  req_cycles = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [8:0]  rsp_prg_slot0_bank;
   logic [8:0]  rsp_prg_slot1_bank;
   logic [8:0]  rsp_prg_slot2_bank;
   logic [8:0]  rsp_prg_slot3_bank;
   logic [7:0]  rsp_chr_slot0_bank;
   logic [7:0]  rsp_chr_slot1_bank;
   logic [7:0]  rsp_chr_slot2_bank;
   logic [7:0]  rsp_chr_slot3_bank;
   logic        rsp_mirror_select;
   logic        rsp_irq_level;

   // predicted mapper state
   logic [9:0]  bank_count_q = BANK_COUNT_RST;
   logic [7:0]  bank_q = '0;
   logic [7:0]  mode_q = '0;
   logic [7:0]  bank_table_q [TBL_DEPTH] = '{default: 8'h00};
   logic [15:0] irq_count_q = '0;
   logic        irq_armed_q = 1'b0;
   logic        irq_pending_q = 1'b0;

   logic [15:0] map_codes [9] = '{ADDR_BANK, ADDR_MODE, ADDR_TBL0, ADDR_TBL1, ADDR_TBL2,
                                  ADDR_TBL3, ADDR_TBL4, ADDR_TBL5, ADDR_TBL6};

   bus_word_type pending_words [$];
   bank_map_type expected_maps [$];
   bus_word_type offered;
   int        send_gap = 0;
   int        recv_wait = 0;
   bit        send_calm = 1'b0;
   bit        recv_calm = 1'b0;
   int        words_sent = 0;
   int        mismatch_count = 0;
   int        cycle_count = 0;
   bit        hold_off = 1'b0;
   bit        hold_done = 1'b0;
   int        hold_left = 0;

   cartridge_bank_mapper_with_irq_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_data           (req_data),
      .req_cycles         (req_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prg_slot0_bank (rsp_prg_slot0_bank),
      .rsp_prg_slot1_bank (rsp_prg_slot1_bank),
      .rsp_prg_slot2_bank (rsp_prg_slot2_bank),
      .rsp_prg_slot3_bank (rsp_prg_slot3_bank),
      .rsp_chr_slot0_bank (rsp_chr_slot0_bank),
      .rsp_chr_slot1_bank (rsp_chr_slot1_bank),
      .rsp_chr_slot2_bank (rsp_chr_slot2_bank),
      .rsp_chr_slot3_bank (rsp_chr_slot3_bank),
      .rsp_mirror_select  (rsp_mirror_select),
      .rsp_irq_level      (rsp_irq_level)
   );

   always #6 clock = ~clock;

   function automatic bank_map_type step_mapper(bus_word_type w);
      bank_map_type m;
      logic [8:0]   base;
      if (w.op == OP_WRITE) begin
         case (w.address & DECODE_MASK)
            ADDR_BANK: bank_q = w.data;
            ADDR_MODE: mode_q = w.data;
            ADDR_CNT_LO: begin
               irq_count_q[7:0] = w.data;
               irq_pending_q = 1'b0;
            end
            ADDR_CNT_HI: begin
               irq_armed_q = mode_q[MODE_ARM_BIT];
               irq_count_q[15:8] = w.data;
            end
            ADDR_TBL0: bank_table_q[0] = w.data;
            ADDR_TBL1: bank_table_q[1] = w.data;
            ADDR_TBL2: bank_table_q[2] = w.data;
            ADDR_TBL3: bank_table_q[3] = w.data;
            ADDR_TBL4: bank_table_q[4] = w.data;
            ADDR_TBL5: bank_table_q[5] = w.data;
            ADDR_TBL6: bank_table_q[6] = w.data;
            default: ;
         endcase
      end else if (irq_armed_q) begin
         if ({6'd0, w.cycles} > irq_count_q) begin
            irq_pending_q = 1'b1;
            irq_armed_q = 1'b0;
            irq_count_q = CNT_RELOAD;
         end else begin
            irq_count_q = irq_count_q - {6'd0, w.cycles};
         end
      end
      if (mode_q[MODE_WINDOW_BIT]) begin
         base = {4'd0, bank_q[3], 4'd0};
         for (int k = 0; k < 3; k++) m.prg[k] = {5'd0, bank_table_q[k][3:0]} | base;
         m.prg[3] = 9'h00F | base;
      end else if (mode_q[MODE_32K_BIT]) begin
         base = {bank_q[7:1], 2'b00};
         for (int k = 0; k < 4; k++) m.prg[k] = base + 9'(k);
      end else begin
         m.prg[0] = {bank_q, 1'b0};
         m.prg[1] = {bank_q, 1'b1};
         m.prg[2] = bank_count_q[8:0] - 9'd2;
         m.prg[3] = bank_count_q[8:0] - 9'd1;
      end
      for (int k = 0; k < 4; k++) m.chr[k] = bank_table_q[3 + k];
      m.mirror = ~mode_q[MODE_MIRROR_BIT];
      m.irq = irq_pending_q;
      return m;
   endfunction

   function automatic int pick_wait(ref bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic logic [15:0] spare_bits();
      return 16'($urandom) & ~DECODE_MASK;
   endfunction

   task automatic note_error(string msg);
      $display("error: %s", msg);
      mismatch_count++;
   endtask

   task automatic push_write(logic [15:0] address, logic [7:0] data);
      bus_word_type w;
      w.op = OP_WRITE;
      w.address = address;
      w.data = data;
      w.cycles = 10'($urandom);
      pending_words.push_back(w);
   endtask

   task automatic push_clock(logic [9:0] cycles);
      bus_word_type w;
      w.op = OP_CLOCK;
      w.address = 16'($urandom);
      w.data = 8'($urandom);
      w.cycles = cycles;
      pending_words.push_back(w);
   endtask

   task automatic add_directed();
      push_write(ADDR_BANK, 8'hFF);
      push_write(ADDR_TBL0, 8'hFF);
      push_write(ADDR_TBL1, 8'hA5);
      push_write(ADDR_TBL2, 8'h5A);
      push_write(ADDR_TBL3, 8'hFF);
      push_write(ADDR_TBL4, 8'h01);
      push_write(ADDR_TBL5, 8'h80);
      push_write(16'hFFFF, 8'h7F);
      push_write(ADDR_MODE, 8'h11);
      push_write(ADDR_MODE, 8'h08);
      // addresses that decode to nothing, below cartridge space too
      push_write(16'h8002, 8'h55);
      push_write(16'h0000, 8'hFF);
      push_write(16'h7FFF, 8'h00);
      push_write(ADDR_BANK, 8'h00);
      // arm, count down to zero, then underflow
      push_write(ADDR_MODE, 8'h80);
      push_write(ADDR_CNT_LO, 8'h05);
      push_write(ADDR_CNT_HI, 8'h00);
      push_clock(10'd0);
      push_clock(10'd3);
      push_clock(10'd2);
      push_clock(10'd1);
      push_clock(10'h3FF);
      push_write(ADDR_CNT_LO | ~DECODE_MASK, 8'h00);
      // high byte with arm bit clear leaves the counter idle
      push_write(ADDR_MODE, 8'h00);
      push_write(ADDR_CNT_HI, 8'hFF);
      push_clock(10'h3FF);
   endtask

   task automatic add_random(int n);
      int         made;
      int         pick;
      int         runs;
      logic [7:0] mode_byte;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            push_write(map_codes[$urandom_range(0, 8)] | spare_bits(), 8'($urandom));
            made++;
         end else if (pick < 65) begin
            mode_byte = 8'($urandom);
            if ($urandom_range(0, 4) != 0) mode_byte[MODE_ARM_BIT] = 1'b1;
            push_write(ADDR_MODE | spare_bits(), mode_byte);
            push_write(ADDR_CNT_LO | spare_bits(), 8'($urandom));
            push_write(ADDR_CNT_HI | spare_bits(),
                       ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
            runs = $urandom_range(2, 8);
            repeat (runs) begin
               push_clock($urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 40)));
            end
            made += 3 + runs;
         end else if (pick < 80) begin
            push_clock(10'($urandom));
            made++;
         end else if (pick < 92) begin
            push_write(16'($urandom), 8'($urandom));
            made++;
         end else begin
            // high byte without a fresh low byte, then a clock
            push_write(ADDR_CNT_HI | spare_bits(), 8'($urandom));
            push_clock(10'($urandom_range(0, 300)));
            made += 2;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_maps.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_bank_count(logic [9:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bank_count_q = value;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_maps.push_back(step_mapper(offered));
            words_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               offered = pending_words.pop_front();
               req_op <= offered.op;
               req_address <= offered.address;
               req_data <= offered.data;
               req_cycles <= offered.cycles;
               req_valid <= 1'b1;
               send_gap = pick_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin
      bank_map_type got;
      bank_map_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.prg = {rsp_prg_slot3_bank, rsp_prg_slot2_bank, rsp_prg_slot1_bank,
                       rsp_prg_slot0_bank};
            got.chr = {rsp_chr_slot3_bank, rsp_chr_slot2_bank, rsp_chr_slot1_bank,
                       rsp_chr_slot0_bank};
            got.mirror = rsp_mirror_select;
            got.irq = rsp_irq_level;
            if (expected_maps.size() == 0) begin
               note_error("result word with nothing expected");
            end else begin
               want = expected_maps.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (got.prg[k] !== want.prg[k])
                     note_error($sformatf("prg_slot%0d_bank got %0h expected %0h",
                                          k, got.prg[k], want.prg[k]));
                  if (got.chr[k] !== want.chr[k])
                     note_error($sformatf("chr_slot%0d_bank got %0h expected %0h",
                                          k, got.chr[k], want.chr[k]));
               end
               if (got.mirror !== want.mirror)
                  note_error($sformatf("mirror_select got %0b expected %0b",
                                       got.mirror, want.mirror));
               if (got.irq !== want.irq)
                  note_error($sformatf("irq_level got %0b expected %0b", got.irq, want.irq));
            end
            recv_wait = pick_wait(recv_calm);
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid) recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one long receiver hold-off while words keep coming
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) hold_off <= 1'b0;
         end else if (!hold_done && words_sent >= 700) begin
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached");
         $display("cartridge_bank_mapper_with_irq_top_test: FAIL");
         $finish;
      end
   end

   initial begin
      logic [9:0] counts [7];
      counts = '{10'd2, 10'd512, 10'd1, 10'd0, 10'd1023, 10'd300, 10'd32};
      add_directed();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (counts[i]) begin
         wait_drained();
         write_bank_count(counts[i]);
         add_random(PHASE_WORDS);
      end
      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cartridge_bank_mapper_with_irq_top_test: PASS");
      end else begin
         $display("cartridge_bank_mapper_with_irq_top_test: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_prg_map.sv
hw/rtl/cartridge_bank_mapper_with_irq_top.sv
hw/rtl/cbm_checker.sv
dv/cartridge_bank_mapper_with_irq_top_test.sv
